// ===== src/sefg_pkg.sv =====
// Shared types, opcodes and helpers for the spectral-element Fourier gradient.
// Used by spectral_element_fourier_gradient, sefg_checker and testbench; no other dependencies.
package sefg_pkg;

  localparam int DATA_W  = 32;
  localparam int ACC_W   = 52;
  localparam int ORDER_W = 12;
  localparam int IDX_W   = 3;
  localparam int SEL_W   = 3;
  localparam int PROD_W  = 64;
  localparam int GEO_MATS = 5;

  // input opcodes
  localparam logic [1:0] OP_DERIV   = 2'd0;
  localparam logic [1:0] OP_GEOM    = 2'd1;
  localparam logic [1:0] OP_FIELD   = 2'd2;
  localparam logic [1:0] OP_COMPUTE = 2'd3;

  // derivative matrix selectors
  localparam logic [SEL_W-1:0] DER_PLAIN = 3'd0;
  localparam logic [SEL_W-1:0] DER_AXIAL = 3'd1;

  // geometry factor selectors
  localparam logic [SEL_W-1:0] GEO_DSX  = 3'd0;
  localparam logic [SEL_W-1:0] GEO_DSE  = 3'd1;
  localparam logic [SEL_W-1:0] GEO_DZX  = 3'd2;
  localparam logic [SEL_W-1:0] GEO_DZE  = 3'd3;
  localparam logic [SEL_W-1:0] GEO_INVS = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_AXIAL     = 2'd0;
  localparam logic [1:0] CFG_MAX_ORDER = 2'd1;
  localparam logic [1:0] CFG_NYQUIST   = 2'd2;

  // accumulator slots
  localparam logic [3:0] A_GR = 4'd0;
  localparam logic [3:0] A_GI = 4'd1;
  localparam logic [3:0] A_UR = 4'd2;
  localparam logic [3:0] A_UI = 4'd3;
  localparam logic [3:0] A_AR = 4'd4;
  localparam logic [3:0] A_AI = 4'd5;
  localparam logic [3:0] A_C0 = 4'd6;
  localparam logic [3:0] A_C1 = 4'd7;
  localparam logic [3:0] A_C2 = 4'd8;
  localparam logic [3:0] A_C3 = 4'd9;
  localparam logic [3:0] A_C4 = 4'd10;
  localparam logic [3:0] A_C5 = 4'd11;
  localparam int         NUM_ACC = 12;
  localparam int         NUM_SAT = 6;

  localparam logic [3:0] GEO_STEPS = 4'd10;

  typedef enum logic [4:0] {
    K_NOP, K_GU_RE, K_GU_IM, K_UG_RE, K_UG_IM, K_AR, K_AI, K_LATCH,
    K_C0A, K_C1A, K_C0B, K_C1B, K_C4A, K_C5A, K_C4B, K_C5B, K_C2, K_C3
  } uop_kind_t;

  typedef struct packed {
    uop_kind_t kind;
    logic      first;
  } uop_t;

  // geometry phase: pairs share one geometry entry so the read is reused
  function automatic uop_t geo_uop(input logic [3:0] n);
    uop_t u;
    u.first = 1'b0;
    u.kind  = K_NOP;
    case (n)
      4'd0: begin u.kind = K_C0A; u.first = 1'b1; end
      4'd1: begin u.kind = K_C1A; u.first = 1'b1; end
      4'd2: u.kind = K_C0B;
      4'd3: u.kind = K_C1B;
      4'd4: begin u.kind = K_C4A; u.first = 1'b1; end
      4'd5: begin u.kind = K_C5A; u.first = 1'b1; end
      4'd6: u.kind = K_C4B;
      4'd7: u.kind = K_C5B;
      4'd8: begin u.kind = K_C2; u.first = 1'b1; end
      4'd9: begin u.kind = K_C3; u.first = 1'b1; end
      default: u.kind = K_NOP;
    endcase
    return u;
  endfunction

  function automatic logic [SEL_W-1:0] geo_sel(input logic [3:0] n);
    logic [SEL_W-1:0] s;
    case (n)
      4'd0, 4'd1: s = GEO_DZE;
      4'd2, 4'd3: s = GEO_DZX;
      4'd4, 4'd5: s = GEO_DSE;
      4'd6, 4'd7: s = GEO_DSX;
      default:    s = GEO_INVS;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] acc_dest(input uop_kind_t k);
    logic [3:0] d;
    case (k)
      K_GU_RE:      d = A_GR;
      K_GU_IM:      d = A_GI;
      K_UG_RE:      d = A_UR;
      K_UG_IM:      d = A_UI;
      K_AR:         d = A_AR;
      K_AI:         d = A_AI;
      K_C0A, K_C0B: d = A_C0;
      K_C1A, K_C1B: d = A_C1;
      K_C2:         d = A_C2;
      K_C3:         d = A_C3;
      K_C4A, K_C4B: d = A_C4;
      K_C5A, K_C5B: d = A_C5;
      default:      d = A_GR;
    endcase
    return d;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if ((&x[ACC_W-1:DATA_W-1]) || !(|x[ACC_W-1:DATA_W-1])) begin
      r = x[DATA_W-1:0];
    end else if (x[ACC_W-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== src/sefg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sefg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 25
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/spectral_element_fourier_gradient.sv =====
// Gradient of one Fourier order of a complex field on a spectral element.
// Usage: load items write matrix and field entries; a compute item walks every grid point.
// The input channel (in_*) carries load and compute words; op selects the kind.
// Loads cause no result. A compute word streams one result
// word per grid point on out_*, row-major, with out_last on the final point.
// All arithmetic runs through one shared 33x33 multiplier with a registered
// product and a small accumulator bank, sequenced per grid point:
//   4*P multiplies for the two matrix contractions, 2 for i*alpha*u,
//   10 for the geometry factors, plus the latch, pipeline drain and output
//   steps; P*P points per compute word.
// The input is stalled for the whole compute word.
// The result sits in an output register; the next point is computed while
// the receiver stalls, and the sequencer waits only if a second result is
// ready before the first is taken.
// Synchronous active-low reset clears the control state and configuration;
// matrix memories are not cleared and must be loaded before use.
// Write configuration words (cfg_*) only while idle.
module spectral_element_fourier_gradient #(
  parameter int POINTS_PER_SIDE = 5
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_op,
  input  logic [sefg_pkg::SEL_W-1:0]         in_which,
  input  logic [sefg_pkg::IDX_W-1:0]         in_row,
  input  logic [sefg_pkg::IDX_W-1:0]         in_col,
  input  logic signed [sefg_pkg::DATA_W-1:0] in_value_re,
  input  logic signed [sefg_pkg::DATA_W-1:0] in_value_im,
  input  logic [sefg_pkg::ORDER_W-1:0]       in_order,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [sefg_pkg::IDX_W-1:0]         out_point_row,
  output logic [sefg_pkg::IDX_W-1:0]         out_point_col,
  output logic signed [sefg_pkg::DATA_W-1:0] out_comp0_re,
  output logic signed [sefg_pkg::DATA_W-1:0] out_comp0_im,
  output logic signed [sefg_pkg::DATA_W-1:0] out_comp1_re,
  output logic signed [sefg_pkg::DATA_W-1:0] out_comp1_im,
  output logic signed [sefg_pkg::DATA_W-1:0] out_comp2_re,
  output logic signed [sefg_pkg::DATA_W-1:0] out_comp2_im,
  output logic                               out_last,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [sefg_pkg::ORDER_W-1:0]       cfg_wdata
);

  import sefg_pkg::*;

  localparam int PP   = POINTS_PER_SIDE * POINTS_PER_SIDE;
  localparam int GD   = GEO_MATS * PP;
  localparam int AW   = $clog2(PP);
  localparam int GW   = $clog2(GD);
  localparam int CW   = $clog2(POINTS_PER_SIDE);
  localparam int SW   = $clog2(NUM_SAT);
  localparam logic [CW-1:0] LAST_IDX = CW'(POINTS_PER_SIDE - 1);
  localparam logic [AW-1:0] STRIDE   = AW'(POINTS_PER_SIDE);
  localparam logic [AW-1:0] LAST_PT  = AW'(PP - 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_GU    = 8'b0000_0010,
    S_UG    = 8'b0000_0100,
    S_ALPHA = 8'b0000_1000,
    S_LATCH = 8'b0001_0000,
    S_GEO   = 8'b0010_0000,
    S_FIN   = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic               axial_r;
  logic [ORDER_W-1:0] max_order_r;
  logic               nyq_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axial_r     <= 1'b0;
      max_order_r <= '0;
      nyq_en_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AXIAL:     axial_r     <= cfg_wdata[0];
        CFG_MAX_ORDER: max_order_r <= cfg_wdata;
        CFG_NYQUIST:   nyq_en_r    <= cfg_wdata[0];
        default:       ;
      endcase
    end
  end

  // load decode
  logic          in_acc;
  logic          pos_ok;
  logic [AW-1:0] ld_idx;
  logic [GW-1:0] ld_gidx;
  logic          we_plain, we_axial, we_geo, we_fld;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign pos_ok   = ({1'b0, in_row} < 4'(POINTS_PER_SIDE)) &&
                    ({1'b0, in_col} < 4'(POINTS_PER_SIDE));
  assign ld_idx   = AW'(AW'(in_row) * STRIDE + AW'(in_col));
  assign ld_gidx  = GW'(GW'(in_which) * GW'(PP) + GW'(ld_idx));
  assign we_plain = in_acc && pos_ok && in_op == OP_DERIV && in_which == DER_PLAIN;
  assign we_axial = in_acc && pos_ok && in_op == OP_DERIV && in_which == DER_AXIAL;
  assign we_geo   = in_acc && pos_ok && in_op == OP_GEOM && in_which <= GEO_INVS;
  assign we_fld   = in_acc && pos_ok && in_op == OP_FIELD;

  // sequencer counters
  logic [CW-1:0]      i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [AW-1:0]      p_r, p_nxt, ip_r, ip_nxt, kp_r, kp_nxt;
  logic               im_r, im_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [ORDER_W-1:0] alpha_r, alpha_nxt;

  // memory read side
  logic [AW-1:0]        plain_ra, axial_ra, fld_ra;
  logic [GW-1:0]        geo_ra;
  logic [DATA_W-1:0]    plain_rd, axial_rd, geo_rd;
  logic [2*DATA_W-1:0]  fld_rd;

  sefg_ram #(.WIDTH(DATA_W), .DEPTH(PP)) u_plain (
    .clk(clk), .we(we_plain), .waddr(ld_idx), .wdata(in_value_re),
    .raddr(plain_ra), .rdata(plain_rd));

  sefg_ram #(.WIDTH(DATA_W), .DEPTH(PP)) u_axial (
    .clk(clk), .we(we_axial), .waddr(ld_idx), .wdata(in_value_re),
    .raddr(axial_ra), .rdata(axial_rd));

  sefg_ram #(.WIDTH(DATA_W), .DEPTH(GD)) u_geo (
    .clk(clk), .we(we_geo), .waddr(ld_gidx), .wdata(in_value_re),
    .raddr(geo_ra), .rdata(geo_rd));

  sefg_ram #(.WIDTH(2*DATA_W), .DEPTH(PP)) u_fld (
    .clk(clk), .we(we_fld), .waddr(ld_idx), .wdata({in_value_re, in_value_im}),
    .raddr(fld_ra), .rdata(fld_rd));

  // issue stage
  uop_t u0, u1_r, u2_r;

  always_comb begin
    u0.kind  = K_NOP;
    u0.first = 1'b0;
    plain_ra = kp_r + AW'(j_r);
    axial_ra = kp_r + AW'(i_r);
    fld_ra   = p_r;
    geo_ra   = GW'(GW'(geo_sel(cnt_r)) * GW'(PP) + GW'(p_r));
    case (state_r)
      S_GU: begin
        u0.kind  = im_r ? K_GU_IM : K_GU_RE;
        u0.first = (k_r == '0);
        plain_ra = kp_r + AW'(i_r);
        fld_ra   = kp_r + AW'(j_r);
      end
      S_UG: begin
        u0.kind  = im_r ? K_UG_IM : K_UG_RE;
        u0.first = (k_r == '0);
        fld_ra   = ip_r + AW'(k_r);
      end
      S_ALPHA: begin
        u0.kind  = im_r ? K_AI : K_AR;
        u0.first = 1'b1;
      end
      S_LATCH: begin
        if (cnt_r == '0) begin
          u0.kind = K_LATCH;
        end
      end
      S_GEO:   u0 = geo_uop(cnt_r);
      default: ;
    endcase
  end

  // operand select and shared multiplier
  logic signed [DATA_W-1:0] sat_r [NUM_SAT];
  logic signed [DATA_W-1:0] dm_rd, fld_re, fld_im, a_v, b_v;
  logic signed [PROD_W-1:0] prod_r;

  assign dm_rd  = axial_r ? axial_rd : plain_rd;
  assign fld_re = fld_rd[2*DATA_W-1:DATA_W];
  assign fld_im = fld_rd[DATA_W-1:0];

  logic a_uns;

  always_comb begin
    a_v   = geo_rd;
    b_v   = sat_r[A_GR[SW-1:0]];
    a_uns = 1'b0;
    case (u1_r.kind)
      K_GU_RE: begin a_v = dm_rd;  b_v = fld_re;   end
      K_GU_IM: begin a_v = dm_rd;  b_v = fld_im;   end
      K_UG_RE: begin a_v = fld_re; b_v = plain_rd; end
      K_UG_IM: begin a_v = fld_im; b_v = plain_rd; end
      K_AR: begin a_v = DATA_W'(alpha_r); b_v = fld_im; a_uns = 1'b1; end
      K_AI: begin a_v = DATA_W'(alpha_r); b_v = fld_re; a_uns = 1'b1; end
      K_C0A, K_C4A: b_v = sat_r[A_GR[SW-1:0]];
      K_C1A, K_C5A: b_v = sat_r[A_GI[SW-1:0]];
      K_C0B, K_C4B: b_v = sat_r[A_UR[SW-1:0]];
      K_C1B, K_C5B: b_v = sat_r[A_UI[SW-1:0]];
      K_C2:         b_v = sat_r[A_AR[SW-1:0]];
      K_C3:         b_v = sat_r[A_AI[SW-1:0]];
      default:      ;
    endcase
  end

  logic signed [DATA_W:0] a_op, b_op;
  assign a_op = a_uns ? $signed({1'b0, a_v}) : $signed({a_v[DATA_W-1], a_v});
  assign b_op = $signed({b_v[DATA_W-1], b_v});

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a_op) * PROD_W'(b_op);
  end

  // accumulate stage
  logic signed [ACC_W-1:0] acc_r [NUM_ACC];
  logic signed [ACC_W-1:0] addend;
  logic [3:0]              dst;

  always_comb begin
    dst = acc_dest(u2_r.kind);
    case (u2_r.kind)
      K_AR:    addend = ACC_W'(-prod_r);
      K_AI:    addend = ACC_W'(prod_r);
      default: addend = ACC_W'(prod_r >>> 16);
    endcase
  end

  always_ff @(posedge clk) begin
    if (u2_r.kind == K_LATCH) begin
      for (int n = 0; n < NUM_SAT; n++) begin
        sat_r[n] <= sat32(acc_r[n]);
      end
    end else if (u2_r.kind != K_NOP) begin
      acc_r[dst] <= u2_r.first ? addend : acc_r[dst] + addend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u1_r <= '{kind: K_NOP, first: 1'b0};
      u2_r <= '{kind: K_NOP, first: 1'b0};
    end else begin
      u1_r <= u0;
      u2_r <= u1_r;
    end
  end

  // result formation
  logic signed [DATA_W-1:0] c0, c1, c2, c3, c4, c5;
  logic signed [DATA_W-1:0] r0, r1, r2, r3, r4, r5;
  logic                     emit;

  assign c0 = sat32(acc_r[A_C0]);
  assign c1 = sat32(acc_r[A_C1]);
  assign c2 = sat32(acc_r[A_C2]);
  assign c3 = sat32(acc_r[A_C3]);
  assign c4 = sat32(acc_r[A_C4]);
  assign c5 = sat32(acc_r[A_C5]);

  always_comb begin
    r0 = c0; r1 = c1; r2 = c2; r3 = c3; r4 = c4; r5 = c5;
    if (axial_r && i_r == '0) begin
      if (alpha_r == '0) begin
        r0 = '0; r1 = '0; r2 = '0; r3 = '0;
      end else if (alpha_r == ORDER_W'(1)) begin
        // comp1 = i * comp0, negation saturated
        r2 = (c1 == {1'b1, {(DATA_W-1){1'b0}}}) ? {1'b0, {(DATA_W-1){1'b1}}} : -c1;
        r3 = c0;
        r4 = '0; r5 = '0;
      end else begin
        r0 = '0; r1 = '0; r2 = '0; r3 = '0; r4 = '0; r5 = '0;
      end
    end
    if (nyq_en_r && alpha_r == max_order_r) begin
      r0 = '0; r1 = '0; r2 = '0; r3 = '0; r4 = '0; r5 = '0;
    end
  end

  logic out_valid_r;
  assign emit = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_point_row <= IDX_W'(i_r);
      out_point_col <= IDX_W'(j_r);
      out_comp0_re  <= r0;
      out_comp0_im  <= r1;
      out_comp1_re  <= r2;
      out_comp1_im  <= r3;
      out_comp2_re  <= r4;
      out_comp2_im  <= r5;
      out_last      <= (p_r == LAST_PT);
    end
  end

  assign out_valid = out_valid_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r; j_nxt = j_r; k_nxt = k_r;
    p_nxt = p_r; ip_nxt = ip_r; kp_nxt = kp_r;
    im_nxt = im_r; cnt_nxt = cnt_r; alpha_nxt = alpha_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_op == OP_COMPUTE) begin
          alpha_nxt = in_order;
          i_nxt = '0; j_nxt = '0; k_nxt = '0;
          p_nxt = '0; ip_nxt = '0; kp_nxt = '0;
          im_nxt = 1'b0;
          state_nxt = S_GU;
        end
      end
      S_GU, S_UG: begin
        im_nxt = !im_r;
        if (im_r) begin
          if (k_r == LAST_IDX) begin
            k_nxt = '0;
            kp_nxt = '0;
            state_nxt = (state_r == S_GU) ? S_UG : S_ALPHA;
          end else begin
            k_nxt = k_r + CW'(1);
            kp_nxt = kp_r + STRIDE;
          end
        end
      end
      S_ALPHA: begin
        im_nxt = !im_r;
        if (im_r) begin
          cnt_nxt = '0;
          state_nxt = S_LATCH;
        end
      end
      S_LATCH: begin
        // an idle slot after the latch so the saturated sums are in place
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd1) begin
          cnt_nxt = '0;
          state_nxt = S_GEO;
        end
      end
      S_GEO: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == GEO_STEPS - 4'd1) begin
          cnt_nxt = '0;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // drain the multiply and accumulate stages
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd1) begin
          cnt_nxt = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit) begin
          if (p_r == LAST_PT) begin
            state_nxt = S_IDLE;
          end else begin
            p_nxt = p_r + AW'(1);
            k_nxt = '0; kp_nxt = '0; im_nxt = 1'b0;
            if (j_r == LAST_IDX) begin
              j_nxt = '0;
              i_nxt = i_r + CW'(1);
              ip_nxt = ip_r + STRIDE;
            end else begin
              j_nxt = j_r + CW'(1);
            end
            state_nxt = S_GU;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r <= '0; j_r <= '0; k_r <= '0;
      p_r <= '0; ip_r <= '0; kp_r <= '0;
      im_r <= 1'b0; cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt;
      p_r <= p_nxt; ip_r <= ip_nxt; kp_r <= kp_nxt;
      im_r <= im_nxt; cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    alpha_r <= alpha_nxt;
  end

endmodule

// ===== tb/sefg_checker.sv =====
// Checker for spectral_element_fourier_gradient: watches the load/compute, result and
// configuration ports, predicts every gradient point and compares it field by field.
// Depends on sefg_pkg for opcodes, selectors and register indexes.
module sefg_checker #(
  parameter int POINTS_PER_SIDE = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [2:0]         in_which,
  input  logic [2:0]         in_row,
  input  logic [2:0]         in_col,
  input  logic signed [31:0] in_value_re,
  input  logic signed [31:0] in_value_im,
  input  logic [11:0]        in_order,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         out_point_row,
  input  logic [2:0]         out_point_col,
  input  logic signed [31:0] out_comp0_re,
  input  logic signed [31:0] out_comp0_im,
  input  logic signed [31:0] out_comp1_re,
  input  logic signed [31:0] out_comp1_im,
  input  logic signed [31:0] out_comp2_re,
  input  logic signed [31:0] out_comp2_im,
  input  logic               out_last,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_wdata,
  output int                 errors,
  output int                 pending
);
  import sefg_pkg::*;

  localparam int P = POINTS_PER_SIDE;
  localparam int NP = P * P;

  typedef struct {
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] comp[6];
    logic               last;
  } grad_point_t;

  grad_point_t grad_queue[$];

  logic               axial_q;
  logic [11:0]        max_order_q;
  logic               nyq_q;
  logic signed [31:0] d_plain[NP];
  logic signed [31:0] d_axial[NP];
  logic signed [31:0] geo[5][NP];
  logic signed [31:0] f_re[NP];
  logic signed [31:0] f_im[NP];

  function automatic longint clip32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // floor of the Q15.16 product
  function automatic longint qmul(input longint a, input longint b);
    longint p;
    p = a * b;
    return p >>> 16;
  endfunction

  task automatic predict_gradient(input logic [11:0] alpha_in);
    longint gr, gi, ur, ui, ar, ai, d, g, alpha;
    longint dsx, dse, dzx, dze, ivs;
    longint c[6];
    grad_point_t pt;
    int p;
    bit nyq;
    alpha = longint'(alpha_in);
    nyq = nyq_q && (alpha_in == max_order_q);
    for (int i = 0; i < P; i++) begin
      for (int j = 0; j < P; j++) begin
        p = i * P + j;
        gr = 0; gi = 0; ur = 0; ui = 0;
        for (int k = 0; k < P; k++) begin
          d = axial_q ? d_axial[k * P + i] : d_plain[k * P + i];
          g = d_plain[k * P + j];
          gr += qmul(d, f_re[k * P + j]);
          gi += qmul(d, f_im[k * P + j]);
          ur += qmul(f_re[i * P + k], g);
          ui += qmul(f_im[i * P + k], g);
        end
        gr = clip32(gr); gi = clip32(gi); ur = clip32(ur); ui = clip32(ui);
        ar = clip32(-alpha * longint'(f_im[p]));
        ai = clip32(alpha * longint'(f_re[p]));
        dsx = geo[GEO_DSX][p]; dse = geo[GEO_DSE][p];
        dzx = geo[GEO_DZX][p]; dze = geo[GEO_DZE][p];
        ivs = geo[GEO_INVS][p];
        c[0] = clip32(qmul(dze, gr) + qmul(dzx, ur));
        c[1] = clip32(qmul(dze, gi) + qmul(dzx, ui));
        c[2] = clip32(qmul(ivs, ar));
        c[3] = clip32(qmul(ivs, ai));
        c[4] = clip32(qmul(dse, gr) + qmul(dsx, ur));
        c[5] = clip32(qmul(dse, gi) + qmul(dsx, ui));
        // on the axis only the regular modes survive
        if (axial_q && i == 0) begin
          if (alpha == 0) begin
            c[0] = 0; c[1] = 0; c[2] = 0; c[3] = 0;
          end else if (alpha == 1) begin
            c[2] = clip32(-c[1]);
            c[3] = c[0];
            c[4] = 0; c[5] = 0;
          end else begin
            for (int k = 0; k < 6; k++) c[k] = 0;
          end
        end
        if (nyq) begin
          for (int k = 0; k < 6; k++) c[k] = 0;
        end
        pt.row = i[2:0];
        pt.col = j[2:0];
        for (int k = 0; k < 6; k++) pt.comp[k] = c[k][31:0];
        pt.last = (p == NP - 1);
        grad_queue.push_back(pt);
      end
    end
  endtask

  task automatic take_word();
    int idx;
    if (in_op == OP_COMPUTE) begin
      predict_gradient(in_order);
    end else if (in_row < P && in_col < P) begin
      idx = in_row * P + in_col;
      case (in_op)
        OP_DERIV: begin
          if (in_which == DER_PLAIN) d_plain[idx] = in_value_re;
          else if (in_which == DER_AXIAL) d_axial[idx] = in_value_re;
        end
        OP_GEOM: begin
          if (in_which <= GEO_INVS) geo[in_which][idx] = in_value_re;
        end
        default: begin
          f_re[idx] = in_value_re;
          f_im[idx] = in_value_im;
        end
      endcase
    end
  endtask

  task automatic check_word();
    grad_point_t exp_pt;
    logic signed [31:0] got[6];
    got = '{out_comp0_re, out_comp0_im, out_comp1_re, out_comp1_im,
            out_comp2_re, out_comp2_im};
    if (grad_queue.size() == 0) begin
      $display("%0t: unexpected result word row %0d col %0d", $time,
               out_point_row, out_point_col);
      errors++;
      return;
    end
    exp_pt = grad_queue.pop_front();
    if (out_point_row !== exp_pt.row) begin
      $display("%0t: point_row expected %0d actual %0d", $time, exp_pt.row, out_point_row);
      errors++;
    end
    if (out_point_col !== exp_pt.col) begin
      $display("%0t: point_col expected %0d actual %0d", $time, exp_pt.col, out_point_col);
      errors++;
    end
    for (int k = 0; k < 6; k++) begin
      if (got[k] !== exp_pt.comp[k]) begin
        $display("%0t: point (%0d,%0d) component word %0d expected %h actual %h",
                 $time, exp_pt.row, exp_pt.col, k, exp_pt.comp[k], got[k]);
        errors++;
      end
    end
    if (out_last !== exp_pt.last) begin
      $display("%0t: last expected %0b actual %0b", $time, exp_pt.last, out_last);
      errors++;
    end
  endtask

  initial errors = 0;
  assign pending = grad_queue.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      axial_q <= 1'b0;
      max_order_q <= '0;
      nyq_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_AXIAL:     axial_q <= cfg_wdata[0];
          CFG_MAX_ORDER: max_order_q <= cfg_wdata;
          CFG_NYQUIST:   nyq_q <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_word();
      if (out_valid && !out_stall) check_word();
    end
  end
endmodule

// ===== tb/testbench.sv =====
// Top of the gradient testbench: clock, reset, stimulus, receiver stalls and verdict.
// Instantiates spectral_element_fourier_gradient and sefg_checker; uses sefg_pkg.
module testbench;
  import sefg_pkg::*;

  localparam int P = 5;
  localparam int WATCHDOG_LIMIT = 20000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_op;
  logic [2:0]         in_which;
  logic [2:0]         in_row;
  logic [2:0]         in_col;
  logic signed [31:0] in_value_re;
  logic signed [31:0] in_value_im;
  logic [11:0]        in_order;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_point_row;
  logic [2:0]         out_point_col;
  logic signed [31:0] out_comp0_re;
  logic signed [31:0] out_comp0_im;
  logic signed [31:0] out_comp1_re;
  logic signed [31:0] out_comp1_im;
  logic signed [31:0] out_comp2_re;
  logic signed [31:0] out_comp2_im;
  logic               out_last;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [11:0]        cfg_wdata;
  int                 errors;
  int                 pending;
  int                 cycle;
  int                 quiet_cycles;
  logic [11:0]        cur_max_order;

  spectral_element_fourier_gradient #(.POINTS_PER_SIDE(P)) uut (.*);

  sefg_checker #(.POINTS_PER_SIDE(P)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // long calm stretch with no idling on either side
  function automatic bit idle_now();
    if (cycle > 9000 && cycle < 17000) return 1'b0;
    return $urandom_range(99) < 6;
  endfunction

  function automatic logic [31:0] rand_value();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(262143) - 131072;
    if (r < 80) return r[0] ? 32'h8000_0000 : 32'h7fff_ffff;
    return $urandom;
  endfunction

  task automatic send(input logic [1:0] op, input logic [2:0] which,
                      input logic [2:0] row, input logic [2:0] col,
                      input logic [31:0] vre, input logic [31:0] vim,
                      input logic [11:0] order);
    bit stalled;
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_which <= which;
    in_row <= row;
    in_col <= col;
    in_value_re <= vre;
    in_value_im <= vim;
    in_order <= order;
    forever begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
      if (!stalled) break;
    end
  endtask

  task automatic compute(input logic [11:0] order);
    send(OP_COMPUTE, 3'($urandom), 3'($urandom), 3'($urandom), $urandom, $urandom, order);
  endtask

  task automatic load_everything();
    for (int r = 0; r < P; r++) begin
      for (int c = 0; c < P; c++) begin
        send(OP_DERIV, DER_PLAIN, 3'(r), 3'(c), $urandom_range(131071) - 65536,
             $urandom, 12'($urandom));
        send(OP_DERIV, DER_AXIAL, 3'(r), 3'(c), $urandom_range(131071) - 65536,
             $urandom, 12'($urandom));
        for (int g = 0; g <= GEO_INVS; g++)
          send(OP_GEOM, 3'(g), 3'(r), 3'(c), $urandom_range(262143) - 131072,
               $urandom, 12'($urandom));
        send(OP_FIELD, 3'($urandom), 3'(r), 3'(c), rand_value(), rand_value(),
             12'($urandom));
      end
    end
  endtask

  task automatic configure(input logic axial, input logic [11:0] max_ord, input logic nyq);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // let a trailing load settle before touching the registers
    repeat (60) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_AXIAL;
    cfg_wdata <= {11'd0, axial};
    @(posedge clk);
    cfg_index <= CFG_MAX_ORDER;
    cfg_wdata <= max_ord;
    @(posedge clk);
    cfg_index <= CFG_NYQUIST;
    cfg_wdata <= {11'd0, nyq};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_max_order = max_ord;
  endtask

  task automatic random_word();
    int r;
    logic [1:0] op;
    logic [2:0] which, row, col;
    logic [11:0] order;
    r = $urandom_range(99);
    if (r < 8) begin
      case ($urandom_range(5))
        0: order = 0;
        1: order = 1;
        2: order = cur_max_order;
        3: order = cur_max_order + 12'd1;
        4: order = 12'($urandom_range(2, 6));
        default: order = 12'($urandom);
      endcase
      compute(order);
      return;
    end
    op = 2'($urandom_range(2));
    which = (op == OP_DERIV) ? 3'($urandom_range(1)) : 3'($urandom_range(4));
    if ($urandom_range(99) < 8) which = 3'($urandom);
    row = 3'($urandom_range(P - 1));
    col = 3'($urandom_range(P - 1));
    if ($urandom_range(99) < 5) row = 3'($urandom);
    if ($urandom_range(99) < 5) col = 3'($urandom);
    send(op, which, row, col, rand_value(), rand_value(), 12'($urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_DERIV;
    in_which = '0;
    in_row = '0;
    in_col = '0;
    in_value_re = '0;
    in_value_im = '0;
    in_order = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_AXIAL;
    cfg_wdata = '0;
    cur_max_order = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    configure(1'b0, 12'd0, 1'b0);
    load_everything();

    // directed: orders, ignored loads, extreme field and geometry values
    compute(0);
    compute(1);
    compute(12'd4095);
    send(OP_DERIV, 3'd2, 0, 0, 32'h7fff_ffff, 0, 0);
    send(OP_GEOM, 3'd7, 1, 1, 32'h8000_0000, 0, 0);
    send(OP_FIELD, 0, 3'd7, 0, 32'h7fff_ffff, 32'h8000_0000, 0);
    send(OP_FIELD, 0, 0, 3'd5, 32'h8000_0000, 32'h7fff_ffff, 0);
    send(OP_FIELD, 0, 2, 2, 32'h7fff_ffff, 32'h8000_0000, 0);
    send(OP_GEOM, GEO_INVS, 2, 2, 32'h7fff_ffff, 0, 0);
    send(OP_GEOM, GEO_DZE, 2, 2, 32'h8000_0000, 0, 0);
    compute(12'd4095);
    configure(1'b1, 12'd4095, 1'b1);
    compute(0);
    compute(1);
    compute(2);
    compute(12'd4095);
    compute(12'd4094);

    configure(1'b1, 12'd3, 1'b0);
    repeat (64) random_word();
    configure(1'b0, 12'd7, 1'b1);
    repeat (64) random_word();
    configure(1'b1, 12'd1, 1'b1);
    repeat (64) random_word();
    configure(1'b0, 12'd4095, 1'b0);
    repeat (64) random_word();

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // receiver: random stalls, and one long hold-off once results flow
  initial begin
    int hold;
    bit held;
    out_stall = 1'b0;
    hold = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && cycle > 1500 && out_valid) begin
        held = 1'b1;
        hold = 3000;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_now();
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    cycle = 0;
    quiet_cycles = 0;
  end
endmodule

// ===== filelist.f =====
src/sefg_pkg.sv
src/sefg_ram.sv
src/spectral_element_fourier_gradient.sv
tb/sefg_checker.sv
tb/testbench.sv
